// ----- rtl/asst_pkg.sv -----
// ----------------------------------------------------------------------------
// asst_pkg: shared types and constants for the service and sleep timer
// Action codes, register indexes, counter width and life test limits.
// ----------------------------------------------------------------------------
package asst_pkg;

    localparam int COUNT_WIDTH = 8;

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [7:0]             t_limit;
    typedef logic [2:0]             t_action;
    typedef logic [2:0]             t_level;
    typedef logic [2:0]             t_cfg_idx;

    // actions
    localparam t_action ACT_LIFE_TICK  = 3'd0;
    localparam t_action ACT_TIMER_TICK = 3'd1;
    localparam t_action ACT_SET_LEVEL  = 3'd2;
    localparam t_action ACT_SET_POWER  = 3'd3;
    localparam t_action ACT_CLR_SVC    = 3'd4;

    // configuration register indexes
    localparam t_cfg_idx CFG_TEST_MODE  = 3'd0;
    localparam t_cfg_idx CFG_LIFE_LOW   = 3'd1;
    localparam t_cfg_idx CFG_LIFE_MID   = 3'd2;
    localparam t_cfg_idx CFG_LIFE_HIGH  = 3'd3;
    localparam t_cfg_idx CFG_UNIT_TICKS = 3'd4;
    localparam t_cfg_idx CFG_BASE_UNITS = 3'd5;

    // register reset values
    localparam t_limit   RST_LIFE_LOW   = 8'd216;
    localparam t_limit   RST_LIFE_MID   = 8'd250;
    localparam t_limit   RST_LIFE_HIGH  = 8'd200;
    localparam t_limit   RST_UNIT_TICKS = 8'd180;
    localparam logic [4:0] RST_BASE_UNITS = 5'd20;

    // short life limits for test mode
    localparam t_limit TEST_LIMIT_LOW  = 8'd5;
    localparam t_limit TEST_LIMIT_MID  = 8'd1;
    localparam t_limit TEST_LIMIT_HIGH = 8'd1;

    localparam t_level MAX_LEVEL = 3'd4;

endpackage

// ----- rtl/asst_in_if.sv -----
// ----------------------------------------------------------------------------
// asst_in_if: event channel
// Carries one action word with its value under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface asst_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [2:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

// ----- rtl/asst_out_if.sv -----
// ----------------------------------------------------------------------------
// asst_out_if: status channel
// Carries one status word per event under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface asst_out_if;
    logic       valid;
    logic       ready;
    logic       service_due;
    logic       function_stopped;
    logic       system_on;
    logic [2:0] timer_level;
    logic       clear_outputs;
    logic       off_tone;
    logic       on_tone;

    modport source (output valid, output service_due, output function_stopped,
                    output system_on, output timer_level, output clear_outputs,
                    output off_tone, output on_tone, input ready);
    modport sink   (input valid, input service_due, input function_stopped,
                    input system_on, input timer_level, input clear_outputs,
                    input off_tone, input on_tone, output ready);
endinterface

// ----- rtl/appliance_service_and_sleep_timer_top.sv -----
// ----------------------------------------------------------------------------
// appliance_service_and_sleep_timer_top: filter life counter and sleep timer
// Each accepted event word passes the input register and then the output register.
// Throughput: one event per cycle unless the output stalls; the state registers close
// the loop in a single pass through the update logic between input and output registers.
// Reset (synchronous, active low) clears all counters, the state and valid flags and the level,
// and loads the configuration registers with their default limits.
// ----------------------------------------------------------------------------
module appliance_service_and_sleep_timer_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  asst_pkg::t_cfg_idx  i_cfg_idx,
    input  logic [7:0]          i_cfg_data,
    asst_in_if.sink             i_in,
    asst_out_if.source          o_out
);

    // configuration
    logic               r_test_mode;
    asst_pkg::t_limit   r_lim_lo, r_lim_mid, r_lim_hi, r_unit_ticks;
    logic [4:0]         r_base_units;

    // state
    asst_pkg::t_count   r_life_lo, r_life_mid, r_life_hi, r_prescale, r_units;
    asst_pkg::t_count   n_life_lo, n_life_mid, n_life_hi, n_prescale, n_units;
    logic               r_svc, r_stop, r_power, n_svc, n_stop, n_power;
    asst_pkg::t_level   r_level, r_seen, n_level, n_seen;

    // input and output stages
    logic               r_in_vld;
    asst_pkg::t_action  r_act;
    logic [2:0]         r_val;
    logic               r_out_vld;
    logic               r_clr, r_off_t, r_on_t, n_clr, n_off_t, n_on_t;
    logic               r_o_svc, r_o_stop, r_o_power;
    asst_pkg::t_level   r_o_level;

    logic               adv;
    logic               fire;

    asst_pkg::t_limit   lim_lo, lim_mid, lim_hi, unit_lim;
    asst_pkg::t_level   lvl_m1;

    assign adv      = !r_out_vld || o_out.ready;
    assign fire     = r_in_vld && adv;
    assign i_in.ready = !r_in_vld || adv;

    assign lim_lo  = r_test_mode ? asst_pkg::TEST_LIMIT_LOW  : r_lim_lo;
    assign lim_mid = r_test_mode ? asst_pkg::TEST_LIMIT_MID  : r_lim_mid;
    assign lim_hi  = r_test_mode ? asst_pkg::TEST_LIMIT_HIGH : r_lim_hi;
    assign lvl_m1  = r_level - 3'd1;
    assign unit_lim = {3'b000, r_base_units} << lvl_m1[1:0];

    always_comb begin
        n_life_lo  = r_life_lo;
        n_life_mid = r_life_mid;
        n_life_hi  = r_life_hi;
        n_prescale = r_prescale;
        n_units    = r_units;
        n_svc      = r_svc;
        n_stop     = r_stop;
        n_power    = r_power;
        n_level    = r_level;
        n_seen     = r_seen;
        n_clr      = 1'b0;
        n_off_t    = 1'b0;
        n_on_t     = 1'b0;
        case (r_act)
            asst_pkg::ACT_LIFE_TICK: begin
                if (!r_svc) begin
                    n_life_lo = r_life_lo + asst_pkg::t_count'(1);
                    if (n_life_lo >= asst_pkg::t_count'(lim_lo)) begin
                        n_life_lo  = '0;
                        n_life_mid = r_life_mid + asst_pkg::t_count'(1);
                        if (n_life_mid >= asst_pkg::t_count'(lim_mid)) begin
                            n_life_mid = '0;
                            n_life_hi  = r_life_hi + asst_pkg::t_count'(1);
                            if (n_life_hi >= asst_pkg::t_count'(lim_hi)) begin
                                n_life_hi = '0;
                                n_stop    = 1'b1;
                                n_svc     = 1'b1;
                                n_level   = '0;
                                n_clr     = 1'b1;
                            end
                        end
                    end
                end
            end
            asst_pkg::ACT_TIMER_TICK: begin
                // a level change restarts both timer counters
                if (r_level != r_seen) begin
                    n_seen     = r_level;
                    n_prescale = '0;
                    n_units    = '0;
                end
                if (r_level != '0) begin
                    n_prescale = n_prescale + asst_pkg::t_count'(1);
                    if (n_prescale >= asst_pkg::t_count'(r_unit_ticks)) begin
                        n_prescale = '0;
                        n_units    = n_units + asst_pkg::t_count'(1);
                        if (n_units >= asst_pkg::t_count'(unit_lim)) begin
                            n_level = '0;
                            n_units = '0;
                            if (r_power) begin
                                n_power = 1'b0;
                                n_off_t = 1'b1;
                                n_clr   = 1'b1;
                            end else begin
                                n_power = 1'b1;
                                n_on_t  = 1'b1;
                            end
                        end
                    end
                end
            end
            asst_pkg::ACT_SET_LEVEL: begin
                if (!r_stop) begin
                    n_level = (r_val > asst_pkg::MAX_LEVEL) ? asst_pkg::MAX_LEVEL : r_val;
                end
            end
            asst_pkg::ACT_SET_POWER: begin
                if (!r_stop) begin
                    n_power = r_val[0];
                end
            end
            asst_pkg::ACT_CLR_SVC: begin
                n_svc      = 1'b0;
                n_stop     = 1'b0;
                n_life_lo  = '0;
                n_life_mid = '0;
                n_life_hi  = '0;
            end
            default: begin
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_test_mode  <= 1'b0;
            r_lim_lo     <= asst_pkg::RST_LIFE_LOW;
            r_lim_mid    <= asst_pkg::RST_LIFE_MID;
            r_lim_hi     <= asst_pkg::RST_LIFE_HIGH;
            r_unit_ticks <= asst_pkg::RST_UNIT_TICKS;
            r_base_units <= asst_pkg::RST_BASE_UNITS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                asst_pkg::CFG_TEST_MODE:  r_test_mode  <= i_cfg_data[0];
                asst_pkg::CFG_LIFE_LOW:   r_lim_lo     <= i_cfg_data;
                asst_pkg::CFG_LIFE_MID:   r_lim_mid    <= i_cfg_data;
                asst_pkg::CFG_LIFE_HIGH:  r_lim_hi     <= i_cfg_data;
                asst_pkg::CFG_UNIT_TICKS: r_unit_ticks <= i_cfg_data;
                asst_pkg::CFG_BASE_UNITS: r_base_units <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    // state and handshake control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_life_lo  <= '0;
            r_life_mid <= '0;
            r_life_hi  <= '0;
            r_prescale <= '0;
            r_units    <= '0;
            r_svc      <= 1'b0;
            r_stop     <= 1'b0;
            r_power    <= 1'b0;
            r_level    <= '0;
            r_seen     <= '0;
            r_in_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (adv) begin
                r_out_vld <= r_in_vld;
            end
            if (fire) begin
                r_life_lo  <= n_life_lo;
                r_life_mid <= n_life_mid;
                r_life_hi  <= n_life_hi;
                r_prescale <= n_prescale;
                r_units    <= n_units;
                r_svc      <= n_svc;
                r_stop     <= n_stop;
                r_power    <= n_power;
                r_level    <= n_level;
                r_seen     <= n_seen;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_act <= i_in.action;
            r_val <= i_in.value;
        end
        if (fire) begin
            r_o_svc   <= n_svc;
            r_o_stop  <= n_stop;
            r_o_power <= n_power;
            r_o_level <= n_level;
            r_clr     <= n_clr;
            r_off_t   <= n_off_t;
            r_on_t    <= n_on_t;
        end
    end

    assign o_out.valid            = r_out_vld;
    assign o_out.service_due      = r_o_svc;
    assign o_out.function_stopped = r_o_stop;
    assign o_out.system_on        = r_o_power;
    assign o_out.timer_level      = r_o_level;
    assign o_out.clear_outputs    = r_clr;
    assign o_out.off_tone         = r_off_t;
    assign o_out.on_tone          = r_on_t;

    // no word may be taken while both stages are full and the output stalls
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_out_vld && !o_out.ready) |-> !i_in.ready)
        else $error("event word accepted into a full pipeline");

    // life counters hold while service is due, unless a clear service word runs
    a_life_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_svc && !(fire && r_act == asst_pkg::ACT_CLR_SVC))
        |=> ($stable(r_life_lo) && $stable(r_life_mid) && $stable(r_life_hi)))
        else $error("life counters moved while service due");

    // a power-on tone comes only with the timer expired and the system on
    a_on_tone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.on_tone)
        |-> (o_out.system_on && o_out.timer_level == '0 && !o_out.off_tone))
        else $error("on tone without timer expiry");

endmodule
